@@ rtl/dnsd_pkg.sv @@
`default_nettype none

package dnsd_pkg;

  // item kinds
  typedef enum logic {
    OpSample = 1'b0,
    OpSync   = 1'b1
  } op_e;

  // result event kinds
  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvStart  = 2'd1,
    EvCancel = 2'd2
  } event_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegSens      = 3'd0,
    RegWhiteDay  = 3'd1,
    RegRedDay    = 3'd2,
    RegWhiteRg   = 3'd3,
    RegWhiteBg   = 3'd4,
    RegRedRg     = 3'd5,
    RegRedBg     = 3'd6
  } reg_idx_e;

  // runtime scene codes
  localparam logic [2:0] SceneWhite = 3'd1;
  localparam logic [2:0] SceneIr    = 3'd2;
  localparam logic [2:0] SceneOff   = 3'd4;

  localparam int unsigned TableSize = 8;
  localparam logic [2:0]  DefaultSens = 3'd2;
  localparam logic [7:0]  BlackLumLimit = 8'd5;
  localparam logic [31:0] BlackExpLimit = 32'd200000;

  // config reset values
  localparam logic [39:0] RstWhiteDay = 40'd40000000;
  localparam logic [39:0] RstRedDay   = 40'd10000000;
  localparam logic [23:0] RstWhiteRg  = 24'd160;
  localparam logic [23:0] RstWhiteBg  = 24'd185;
  localparam logic [23:0] RstRedRg    = 24'd240;
  localparam logic [23:0] RstRedBg    = 24'd240;

  // one queued item, already classified by the front
  typedef struct packed {
    op_e         op;
    logic [31:0] exposure;
    logic [7:0]  ave_lum;
    logic        pitch_black;
    logic [23:0] num_r;
    logic [23:0] num_b;
    logic [15:0] den;
    logic        sync_night;
    logic [2:0]  sync_scene;
  } cmd_t;

  // configuration write
  typedef struct packed {
    logic        we;
    logic [2:0]  idx;
    logic [39:0] wdata;
  } cfg_wr_t;

  // day-to-night brightness thresholds by sensitivity
  function automatic logic [39:0] day_thr(input logic [2:0] idx);
    logic [39:0] thr;
    unique case (idx)
      3'd0: thr = 40'd160000000;
      3'd1: thr = 40'd155000000;
      3'd2: thr = 40'd150000000;
      3'd3: thr = 40'd125000000;
      3'd4: thr = 40'd100000000;
      3'd5: thr = 40'd80000000;
      3'd6: thr = 40'd60000000;
      default: thr = 40'd40000000;
    endcase
    return thr;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dnsd_front.sv @@
`default_nettype none

module dnsd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                op_i,
  input  wire logic [31:0]         exposure_i,
  input  wire logic [7:0]          ave_lum_i,
  input  wire logic [15:0]         sum_red_i,
  input  wire logic [15:0]         sum_green_i,
  input  wire logic [15:0]         sum_blue_i,
  input  wire logic                sync_night_i,
  input  wire logic [2:0]          sync_scene_i,
  output logic                     cmd_valid_o,
  output dnsd_pkg::cmd_t           cmd_o,
  input  wire logic                cmd_pop_i
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dnsd_pkg::cmd_t   mem_q [Depth];
  dnsd_pkg::cmd_t   cls;
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             accept;

  // classify the incoming item
  always_comb begin
    cls.op          = dnsd_pkg::op_e'(op_i);
    cls.exposure    = exposure_i;
    cls.ave_lum     = ave_lum_i;
    cls.pitch_black = (ave_lum_i < dnsd_pkg::BlackLumLimit) &&
                      (exposure_i > dnsd_pkg::BlackExpLimit);
    cls.num_r       = {sum_red_i, 8'h00};
    cls.num_b       = {sum_blue_i, 8'h00};
    cls.den         = (sum_green_i == 16'd0) ? 16'd1 : sum_green_i;
    cls.sync_night  = sync_night_i;
    cls.sync_scene  = sync_scene_i;
  end

  assign full        = (cnt_q == CntW'(Depth));
  assign accept      = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      priority if (accept && !cmd_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!accept && cmd_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/dnsd_div.sv @@
`default_nettype none

module dnsd_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [23:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [23:0]      quot_o
);

  localparam int unsigned Steps = 24;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [23:0]     quo_q;
  logic [15:0]     rem_q;
  logic [15:0]     dvs_q;
  logic [16:0]     trial;
  logic [16:0]     diff;
  logic            fits;

  // one restoring step per cycle
  assign trial = {rem_q, quo_q[23]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[22:0], fits};
      rem_q <= fits ? diff[15:0] : trial[15:0];
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(Steps);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/dnsd_back.sv @@
`default_nettype none

module dnsd_back #(
  parameter int unsigned SENS_LEVELS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dnsd_pkg::cfg_wr_t cfg_i,
  input  wire logic              cmd_valid_i,
  input  wire dnsd_pkg::cmd_t    cmd_i,
  output logic                   cmd_pop_o,
  output logic                   empty,
  input  wire logic              pop,
  output logic [1:0]             event_kind_o,
  output logic                   suggested_night_o,
  output logic                   cancelled_target_night_o
);

  localparam logic [4:0] SensLim = 5'(SENS_LEVELS);
  localparam logic [4:0] TabLim  = 5'(dnsd_pkg::TableSize);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDecide,
    StPost
  } state_e;

  state_e       state_q;

  // configuration
  logic [3:0]   sens_q;
  logic [39:0]  white_day_q, red_day_q;
  logic [23:0]  white_rg_q, white_bg_q, red_rg_q, red_bg_q;

  // detector state
  logic         acc_night_q;
  logic [2:0]   scene_q;
  logic         pend_q;
  logic         tgt_q;

  // item in flight
  logic [39:0]  bright_q;
  logic         black_q;
  logic [39:0]  prod;

  // pending result
  logic [1:0]   kind_q;
  logic         sugg_q, canc_q;
  logic         res_valid_q;

  // dividers
  logic         div_start;
  logic         rg_done, bg_done;
  logic [23:0]  rg_quot, bg_quot;

  logic [2:0]   thr_idx;
  logic [39:0]  thr;
  logic         met;
  logic         target;
  logic         take;

  assign take      = (state_q == StIdle) && cmd_valid_i;
  assign cmd_pop_o = take;
  assign div_start = take && (cmd_i.op == dnsd_pkg::OpSample);
  assign prod      = 40'(cmd_i.exposure) * 40'(cmd_i.ave_lum);

  dnsd_div u_div_rg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.num_r),
    .divisor_i  (cmd_i.den),
    .done_o     (rg_done),
    .quot_o     (rg_quot)
  );

  dnsd_div u_div_bg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.num_b),
    .divisor_i  (cmd_i.den),
    .done_o     (bg_done),
    .quot_o     (bg_quot)
  );

  // switch condition for the current accepted state
  always_comb begin
    thr_idx = ({1'b0, sens_q} < SensLim && {1'b0, sens_q} < TabLim) ?
              sens_q[2:0] : dnsd_pkg::DefaultSens;
    thr     = dnsd_pkg::day_thr(thr_idx);
    target  = !acc_night_q;
    if (!acc_night_q) begin
      met = (bright_q > thr) || black_q;
    end else if (scene_q == dnsd_pkg::SceneWhite) begin
      met = (bright_q < white_day_q) && (rg_quot < white_rg_q) && (bg_quot < white_bg_q);
    end else if (scene_q >= dnsd_pkg::SceneIr && scene_q <= dnsd_pkg::SceneOff) begin
      met = (bright_q < red_day_q) && (rg_quot < red_rg_q) && (bg_quot < red_bg_q);
    end else begin
      met = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q      <= '0;
      white_day_q <= dnsd_pkg::RstWhiteDay;
      red_day_q   <= dnsd_pkg::RstRedDay;
      white_rg_q  <= dnsd_pkg::RstWhiteRg;
      white_bg_q  <= dnsd_pkg::RstWhiteBg;
      red_rg_q    <= dnsd_pkg::RstRedRg;
      red_bg_q    <= dnsd_pkg::RstRedBg;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        dnsd_pkg::RegSens:     sens_q      <= cfg_i.wdata[3:0];
        dnsd_pkg::RegWhiteDay: white_day_q <= cfg_i.wdata;
        dnsd_pkg::RegRedDay:   red_day_q   <= cfg_i.wdata;
        dnsd_pkg::RegWhiteRg:  white_rg_q  <= cfg_i.wdata[23:0];
        dnsd_pkg::RegWhiteBg:  white_bg_q  <= cfg_i.wdata[23:0];
        dnsd_pkg::RegRedRg:    red_rg_q    <= cfg_i.wdata[23:0];
        dnsd_pkg::RegRedBg:    red_bg_q    <= cfg_i.wdata[23:0];
        default: ;
      endcase
    end
  end

  // sample operands
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      bright_q <= prod;
      black_q  <= cmd_i.pitch_black;
    end
  end

  // sequencer, detector state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                  <= StIdle;
      acc_night_q              <= 1'b0;
      scene_q                  <= '0;
      pend_q                   <= 1'b0;
      tgt_q                    <= 1'b0;
      kind_q                   <= dnsd_pkg::EvNone;
      sugg_q                   <= 1'b0;
      canc_q                   <= 1'b0;
      res_valid_q              <= 1'b0;
      event_kind_o             <= dnsd_pkg::EvNone;
      suggested_night_o        <= 1'b0;
      cancelled_target_night_o <= 1'b0;
    end else begin
      // result valid: set on post, cleared on pop
      if (state_q == StPost && (!res_valid_q || pop)) begin
        res_valid_q <= 1'b1;
      end else if (pop && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (take) begin
            if (cmd_i.op == dnsd_pkg::OpSync) begin
              acc_night_q <= cmd_i.sync_night;
              scene_q     <= cmd_i.sync_scene;
              pend_q      <= 1'b0;
              tgt_q       <= 1'b0;
              kind_q      <= dnsd_pkg::EvNone;
              sugg_q      <= 1'b0;
              canc_q      <= 1'b0;
              state_q     <= StPost;
            end else begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (rg_done && bg_done) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          kind_q <= dnsd_pkg::EvNone;
          sugg_q <= 1'b0;
          canc_q <= 1'b0;
          priority if (!pend_q) begin
            if (met) begin
              pend_q <= 1'b1;
              tgt_q  <= target;
              kind_q <= dnsd_pkg::EvStart;
              sugg_q <= target;
            end
          end else if (met && tgt_q == target) begin
            kind_q <= dnsd_pkg::EvNone;
          end else if (!met) begin
            kind_q <= dnsd_pkg::EvCancel;
            sugg_q <= acc_night_q;
            canc_q <= tgt_q;
            pend_q <= 1'b0;
            tgt_q  <= 1'b0;
          end else begin
            tgt_q  <= target;
            kind_q <= dnsd_pkg::EvStart;
            sugg_q <= target;
          end
          state_q <= StPost;
        end
        StPost: begin
          if (!res_valid_q || pop) begin
            event_kind_o             <= kind_q;
            suggested_night_o        <= sugg_q;
            cancelled_target_night_o <= canc_q;
            state_q                  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign empty = !res_valid_q;

  // a waiting result is never overwritten
  a_post_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPost && res_valid_q && !pop) |=> (state_q == StPost))
    else $error("result register overwritten");

  // items are taken from the queue only when present
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("pop from empty item queue");

  // both ratios are ready when deciding
  a_div_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDecide) |-> (rg_done && bg_done))
    else $error("decision before ratios ready");

  // no candidate target without a pending candidate
  a_tgt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> !tgt_q)
    else $error("stale candidate target");

endmodule

`default_nettype wire

@@ rtl/day_night_switch_detector_unit.sv @@
`default_nettype none

// a sync item goes from the queue straight to the post state; a sample item first
// passes the divide state (24 steps of both parallel ratio dividers) and decide;
// posting waits on an unread result; the next item is taken only after posting;
// a 2-entry item queue accepts items while the back end is busy
// reset: asynchronous active low; clears queue, result, detector state to day,
// and loads config register reset values

module day_night_switch_detector_unit #(
  parameter int unsigned SENS_LEVELS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        op_i,
  input  wire logic [31:0] exposure_i,
  input  wire logic [7:0]  ave_lum_i,
  input  wire logic [15:0] sum_red_i,
  input  wire logic [15:0] sum_green_i,
  input  wire logic [15:0] sum_blue_i,
  input  wire logic        sync_night_i,
  input  wire logic [2:0]  sync_scene_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       event_kind_o,
  output logic             suggested_night_o,
  output logic             cancelled_target_night_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [39:0] cfg_wdata_i
);

  logic              cmd_valid;
  logic              cmd_pop;
  dnsd_pkg::cmd_t    cmd;
  dnsd_pkg::cfg_wr_t cfg;

  // configuration write bundle
  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  dnsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .exposure_i   (exposure_i),
    .ave_lum_i    (ave_lum_i),
    .sum_red_i    (sum_red_i),
    .sum_green_i  (sum_green_i),
    .sum_blue_i   (sum_blue_i),
    .sync_night_i (sync_night_i),
    .sync_scene_i (sync_scene_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  dnsd_back #(
    .SENS_LEVELS (SENS_LEVELS)
  ) u_back (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_i                    (cfg),
    .cmd_valid_i              (cmd_valid),
    .cmd_i                    (cmd),
    .cmd_pop_o                (cmd_pop),
    .empty                    (empty),
    .pop                      (pop),
    .event_kind_o             (event_kind_o),
    .suggested_night_o        (suggested_night_o),
    .cancelled_target_night_o (cancelled_target_night_o)
  );

endmodule

`default_nettype wire
